FILE: sv/pidl_pkg.sv
// Shared types, constants and helpers for the PCI ID text lookup unit.
package pidl_pkg;

  // Configuration register indexes
  localparam logic CFG_VENDOR_KEY = 1'b0;
  localparam logic CFG_DEVICE_KEY = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_VNAME_CHAR = 2'd0;
  localparam logic [1:0] KIND_VNAME_END  = 2'd1;
  localparam logic [1:0] KIND_DNAME_CHAR = 2'd2;
  localparam logic [1:0] KIND_VERDICT    = 2'd3;

  // Verdict codes
  localparam logic [1:0] VERD_FOUND      = 2'd0;
  localparam logic [1:0] VERD_DEV_UNK    = 2'd1;
  localparam logic [1:0] VERD_VEND_UNK   = 2'd2;

  // Characters of interest
  localparam logic [7:0] CHR_NUL = 8'd0;
  localparam logic [7:0] CHR_TAB = 8'd9;
  localparam logic [7:0] CHR_LF  = 8'd10;
  localparam logic [7:0] CHR_CR  = 8'd13;

  // Result queue between the scanner and the output stage
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // One result word
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [1:0] verdict;
  } res_t;

  // Line separators: CR, LF and NUL
  function automatic logic is_sep(input logic [7:0] b);
    is_sep = (b == CHR_CR) || (b == CHR_LF) || (b == CHR_NUL);
  endfunction

  // Upper-case hex character of one key nibble, most significant first
  function automatic logic [7:0] hex_char(input logic [15:0] key, input logic [1:0] pos);
    logic [3:0] nib;
    case (pos)
      2'd0:    nib = key[15:12];
      2'd1:    nib = key[11:8];
      2'd2:    nib = key[7:4];
      default: nib = key[3:0];
    endcase
    if (nib < 4'd10) begin
      hex_char = 8'd48 + {4'd0, nib};
    end else begin
      hex_char = 8'd55 + {4'd0, nib};
    end
  endfunction

endpackage

FILE: sv/pidl_scan.sv
// Front part: key registers and the byte scanner that classifies each text word.
module pidl_scan
  import pidl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        acc,
  input  logic [7:0]  text_byte,
  input  logic        begin_scan,
  output logic        res_valid,
  output res_t        res
);

  localparam logic [3:0] PH_VLINE  = 4'd0;
  localparam logic [3:0] PH_VSKIP  = 4'd1;
  localparam logic [3:0] PH_VGAP   = 4'd2;
  localparam logic [3:0] PH_VNAME  = 4'd3;
  localparam logic [3:0] PH_DSTART = 4'd4;
  localparam logic [3:0] PH_DKEY   = 4'd5;
  localparam logic [3:0] PH_DSKIP  = 4'd6;
  localparam logic [3:0] PH_DGAP   = 4'd7;
  localparam logic [3:0] PH_DNAME  = 4'd8;

  logic [15:0] vendor_key_r, device_key_r;
  logic [3:0]  phase_r, phase_nxt, ph;
  logic [1:0]  cnt_r, cnt_nxt, cnt;
  logic        fin_r, fin_nxt, fin;
  logic        sep;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vendor_key_r <= 16'd0;
      device_key_r <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_VENDOR_KEY: vendor_key_r <= cfg_wdata;
        CFG_DEVICE_KEY: device_key_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Scanner next state and result word
  always_comb begin
    ph        = begin_scan ? PH_VLINE : phase_r;
    cnt       = begin_scan ? 2'd0 : cnt_r;
    fin       = begin_scan ? 1'b0 : fin_r;
    sep       = is_sep(text_byte);
    phase_nxt = ph;
    cnt_nxt   = cnt;
    fin_nxt   = fin;
    res_valid = 1'b0;
    res.kind    = KIND_VERDICT;
    res.ch      = 8'd0;
    res.verdict = VERD_FOUND;
    if (!fin) begin
      case (ph)
        PH_VLINE, PH_DKEY: begin
          if (text_byte == hex_char((ph == PH_VLINE) ? vendor_key_r : device_key_r, cnt)) begin
            cnt_nxt = cnt + 2'd1;
            if (cnt == 2'd3) begin
              phase_nxt = (ph == PH_VLINE) ? PH_VGAP : PH_DGAP;
            end
          end else if (text_byte == CHR_NUL) begin
            fin_nxt     = 1'b1;
            res_valid   = 1'b1;
            res.verdict = VERD_VEND_UNK;
          end else if (sep) begin
            cnt_nxt   = 2'd0;
            phase_nxt = (ph == PH_VLINE) ? PH_VLINE : PH_DSTART;
          end else begin
            cnt_nxt   = 2'd0;
            phase_nxt = (ph == PH_VLINE) ? PH_VSKIP : PH_DSKIP;
          end
        end
        PH_VSKIP, PH_DSKIP: begin
          if (text_byte == CHR_NUL) begin
            fin_nxt     = 1'b1;
            res_valid   = 1'b1;
            res.verdict = VERD_VEND_UNK;
          end else if (sep) begin
            cnt_nxt   = 2'd0;
            phase_nxt = (ph == PH_VSKIP) ? PH_VLINE : PH_DSTART;
          end
        end
        PH_VGAP, PH_VNAME: begin
          if (text_byte == CHR_NUL) begin
            fin_nxt     = 1'b1;
            res_valid   = 1'b1;
            res.verdict = VERD_VEND_UNK;
          end else if (sep) begin
            phase_nxt = PH_DSTART;
            res_valid = 1'b1;
            res.kind  = KIND_VNAME_END;
          end else if (ph == PH_VGAP) begin
            phase_nxt = PH_VNAME;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_VNAME_CHAR;
            res.ch    = text_byte;
          end
        end
        PH_DSTART: begin
          if (text_byte == CHR_TAB) begin
            cnt_nxt   = 2'd0;
            phase_nxt = PH_DKEY;
          end else begin
            fin_nxt     = 1'b1;
            res_valid   = 1'b1;
            res.verdict = VERD_DEV_UNK;
          end
        end
        PH_DGAP, PH_DNAME: begin
          if (sep) begin
            fin_nxt     = 1'b1;
            res_valid   = 1'b1;
            res.verdict = VERD_FOUND;
          end else if (ph == PH_DGAP) begin
            phase_nxt = PH_DNAME;
          end else begin
            res_valid = 1'b1;
            res.kind  = KIND_DNAME_CHAR;
            res.ch    = text_byte;
          end
        end
        default: begin
          phase_nxt = PH_VLINE;
          cnt_nxt   = 2'd0;
        end
      endcase
    end
    if (!acc) begin
      res_valid = 1'b0;
    end
  end

  // Scanner state, updated on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_VLINE;
      cnt_r   <= 2'd0;
      fin_r   <= 1'b0;
    end else if (acc) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

FILE: sv/pidl_queue.sv
// Short result queue that decouples the scanner from the output stage.
module pidl_queue
  import pidl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output res_t head
);

  res_t           mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;

  assign full     = (cnt_r == (QAW+1)'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QAW'(QDEPTH-1)) ? '0 : wp_r + QAW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == QAW'(QDEPTH-1)) ? '0 : rp_r + QAW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (QAW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (QAW+1)'(1);
      end
    end
  end

endmodule

FILE: sv/pidl_out.sv
// Back part: output register that presents result words to the master side.
module pidl_out
  import pidl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_nonempty,
  input  res_t        q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic [1:0]  out_tuser
);

  logic out_valid_r;
  res_t out_r;

  // Take the queue head whenever the register is free or being emptied
  assign q_pop = q_nonempty && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= q_head;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_r.verdict, out_r.ch};
  assign out_tuser  = out_r.kind;

endmodule

FILE: sv/pci_id_text_lookup_unit.sv
// Top level of the PCI ID text lookup unit: scanner, result queue and output stage.
//
//   channel  direction  handshake               payload
//   in_      slave      in_tvalid / in_tready   tdata: text_byte; tuser: begin_scan
//   out_     master     out_tvalid / out_tready tdata: name_char, verdict; tuser: item_kind
//   cfg_     write      cfg_we                  cfg_addr: register index; cfg_wdata
//
// One text word is accepted per cycle while in_tready is high; the scanner classifies it in that cycle.
// A result word is written to the queue at the edge that accepts its text word and
// then loads the out_tvalid register once that register is free or being emptied.
// in_tready drops only while the four-entry result queue is full.
// Reset is synchronous; the scanner restarts at a vendor line start.
module pci_id_text_lookup_unit
  import pidl_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] begin_scan
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] name_char, [9:8] verdict, [15:10] zero
  output logic [1:0]  out_tuser   // [1:0] item_kind
);

  logic acc;
  logic res_valid;
  res_t res;
  logic q_full, q_nonempty, q_pop;
  res_t q_head;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  pidl_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .acc        (acc),
    .text_byte  (in_tdata),
    .begin_scan (in_tuser),
    .res_valid  (res_valid),
    .res        (res)
  );

  pidl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .full      (q_full),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  pidl_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: test/tb_pci_id_text_lookup_unit.sv
// Self-checking testbench for the PCI ID text lookup unit.
module tb_pci_id_text_lookup_unit;
  import pidl_pkg::*;

  localparam bit FIXED = 1'b1;
  localparam bit PRED  = 1'b0;

  // Scanner position inside the text database
  typedef enum logic [3:0] {
    SEEK_VENDOR, SKIP_VLINE, VENDOR_GAP, VENDOR_NAME,
    DEV_LINE_START, DEV_KEY, SKIP_DLINE, DEV_GAP, DEV_NAME
  } scan_state_t;

  // One row of the directed script; res is used only when fixed is set
  typedef struct packed {
    logic [7:0] txt;
    logic       restart;
    logic       fixed;
    logic       has_res;
    res_t       res;
  } text_row_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = CFG_VENDOR_KEY;
  logic [15:0] cfg_wdata  = 16'h0000;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;  // [7:0] text_byte
  logic        in_tuser   = 1'b0;   // [0] begin_scan
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;           // [7:0] name_char, [9:8] verdict, [15:10] zero
  logic [1:0]  out_tuser;           // [1:0] item_kind

  // Predictor state and its copy of the key registers
  scan_state_t scan_at       = SEEK_VENDOR;
  logic [1:0]  key_pos       = 2'd0;
  bit          verdict_given = 1'b0;
  logic [15:0] want_vendor   = 16'h0000;
  logic [15:0] want_device   = 16'h0000;

  res_t        pending_words[$];
  logic [7:0]  db_text[$];
  int          mismatches = 0;
  int          text_count = 0;
  int          burst_left = 0;
  int          ready_left = 0;
  int          ready_mode = 0;

  // Directed script with vendor FFFF and device 0000
  text_row_t script_rows [27] = '{
    '{"F",     1'b0, FIXED, 1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"F",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"F",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"F",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{" ",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{8'hFF,   1'b0, FIXED, 1'b1, '{KIND_VNAME_CHAR, 8'hFF, 2'b00}},
    '{CHR_CR,  1'b0, FIXED, 1'b1, '{KIND_VNAME_END, 8'h00, 2'b00}},
    '{CHR_TAB, 1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"0",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"0",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"0",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"1",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{CHR_LF,  1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{CHR_TAB, 1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"0",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"0",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"0",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"0",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{CHR_CR,  1'b0, FIXED, 1'b1, '{KIND_VERDICT, 8'h00, VERD_FOUND}},
    '{"Z",     1'b0, FIXED, 1'b0, '{2'b00, 8'h00, 2'b00}},
    '{CHR_NUL, 1'b1, FIXED, 1'b1, '{KIND_VERDICT, 8'h00, VERD_VEND_UNK}},
    '{"F",     1'b1, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"F",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"F",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{"F",     1'b0, PRED,  1'b0, '{2'b00, 8'h00, 2'b00}},
    '{CHR_CR,  1'b0, FIXED, 1'b1, '{KIND_VNAME_END, 8'h00, 2'b00}},
    '{CHR_LF,  1'b0, FIXED, 1'b1, '{KIND_VERDICT, 8'h00, VERD_DEV_UNK}}
  };

  pci_id_text_lookup_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #4000000;
    $display("tb_pci_id_text_lookup_unit: errors");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Upper-case hex character of key digit pos, most significant digit first.
  function automatic logic [7:0] key_digit(input logic [15:0] key, input logic [1:0] pos);
    logic [3:0] nib;
    nib = key[4 * (3 - pos) +: 4];
    return (nib < 4'd10) ? 8'h30 + {4'd0, nib} : 8'h37 + {4'd0, nib};
  endfunction

  function automatic res_t close_scan(input logic [1:0] v);
    res_t r;
    r = '0;
    r.kind = KIND_VERDICT;
    r.verdict = v;
    verdict_given = 1'b1;
    return r;
  endfunction

  // Advance the predictor by one text word; returns 1 when a result word is due.
  function automatic bit scan_byte(input logic [7:0] b, input logic restart, output res_t r);
    bit sep;
    bit in_vendor;
    sep = (b == CHR_CR) || (b == CHR_LF) || (b == CHR_NUL);
    r = '0;
    if (restart) begin
      scan_at = SEEK_VENDOR;
      key_pos = 2'd0;
      verdict_given = 1'b0;
    end
    if (verdict_given) return 1'b0;
    case (scan_at)
      SEEK_VENDOR, DEV_KEY: begin
        // Key digits are matched the same way on vendor and device lines.
        in_vendor = (scan_at == SEEK_VENDOR);
        if (b == key_digit(in_vendor ? want_vendor : want_device, key_pos)) begin
          if (key_pos == 2'd3) scan_at = in_vendor ? VENDOR_GAP : DEV_GAP;
          key_pos++;
          return 1'b0;
        end
        key_pos = 2'd0;
        if (b == CHR_NUL) begin
          r = close_scan(VERD_VEND_UNK);
          return 1'b1;
        end
        if (sep) scan_at = in_vendor ? SEEK_VENDOR : DEV_LINE_START;
        else scan_at = in_vendor ? SKIP_VLINE : SKIP_DLINE;
        return 1'b0;
      end
      SKIP_VLINE, SKIP_DLINE: begin
        if (b == CHR_NUL) begin
          r = close_scan(VERD_VEND_UNK);
          return 1'b1;
        end
        if (sep) begin
          key_pos = 2'd0;
          scan_at = (scan_at == SKIP_VLINE) ? SEEK_VENDOR : DEV_LINE_START;
        end
        return 1'b0;
      end
      VENDOR_GAP, VENDOR_NAME: begin
        // A zero here replaces the end-of-name word with a vendor verdict.
        if (b == CHR_NUL) begin
          r = close_scan(VERD_VEND_UNK);
          return 1'b1;
        end
        if (sep) begin
          scan_at = DEV_LINE_START;
          r.kind = KIND_VNAME_END;
          return 1'b1;
        end
        if (scan_at == VENDOR_GAP) begin
          scan_at = VENDOR_NAME;
          return 1'b0;
        end
        r.kind = KIND_VNAME_CHAR;
        r.ch = b;
        return 1'b1;
      end
      DEV_LINE_START: begin
        if (b == CHR_TAB) begin
          key_pos = 2'd0;
          scan_at = DEV_KEY;
          return 1'b0;
        end
        r = close_scan(VERD_DEV_UNK);
        return 1'b1;
      end
      DEV_GAP, DEV_NAME: begin
        if (sep) begin
          r = close_scan(VERD_FOUND);
          return 1'b1;
        end
        if (scan_at == DEV_GAP) begin
          scan_at = DEV_NAME;
          return 1'b0;
        end
        r.kind = KIND_DNAME_CHAR;
        r.ch = b;
        return 1'b1;
      end
      default: begin
        scan_at = SEEK_VENDOR;
        key_pos = 2'd0;
        return 1'b0;
      end
    endcase
  endfunction

  // Write both key registers back to back.
  task automatic load_keys(input logic [15:0] vkey, input logic [15:0] dkey);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_VENDOR_KEY;
    cfg_wdata <= vkey;
    @(posedge clk);
    want_vendor = vkey;
    cfg_addr <= CFG_DEVICE_KEY;
    cfg_wdata <= dkey;
    @(posedge clk);
    want_device = dkey;
    cfg_we <= 1'b0;
  endtask

  // Offer one text word in bursts with random gaps and record what it should produce.
  task automatic send_text(input logic [7:0] b, input logic restart, input bit fixed,
                           input bit fixed_has, input res_t fixed_res);
    res_t r;
    bit   has;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= restart;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (restart || !verdict_given) text_count++;
    has = scan_byte(b, restart, r);
    if (fixed) begin
      has = fixed_has;
      r = fixed_res;
    end
    if (has) pending_words.push_back(r);
  endtask

  // Stop offering words and let the block drain before a register write or the end.
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Any byte that never separates lines.
  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    if (b == CHR_CR || b == CHR_LF) b = "x";
    return b;
  endfunction

  // Append a key line: four hex digits, an optional gap and name, then a separator.
  task automatic add_key_line(input logic [15:0] id);
    logic [7:0] c;
    int         tail;
    for (int i = 0; i < 4; i++) begin
      c = key_digit(id, 2'(i));
      // Lower-case letters never match a key.
      if (c > "9" && $urandom_range(0, 9) == 0) c = c + 8'h20;
      db_text.push_back(c);
    end
    tail = $urandom_range(0, 9);
    if (tail != 0) begin
      db_text.push_back(tail < 8 ? " " : name_byte());
      repeat ($urandom_range(0, 6)) db_text.push_back(name_byte());
    end
    case ($urandom_range(0, 11))
      0:          db_text.push_back(CHR_NUL);
      1, 2, 3:    db_text.push_back(CHR_CR);
      4, 5, 6, 7: db_text.push_back(CHR_LF);
      default: begin
        db_text.push_back(CHR_CR);
        db_text.push_back(CHR_LF);
      end
    endcase
  endtask

  // Build one database: other vendors, usually the wanted vendor and its devices, a zero; or random bytes.
  task automatic make_database();
    logic [15:0] id;
    db_text.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 24)) db_text.push_back(8'($urandom));
      return;
    end
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 3) == 0) db_text.push_back(CHR_TAB);
      id = $urandom_range(0, 1) ? {want_vendor[15:8], 8'($urandom)} : 16'($urandom);
      add_key_line(id);
    end
    if ($urandom_range(0, 9) != 0) begin
      add_key_line(want_vendor);
      repeat ($urandom_range(0, 4)) begin
        db_text.push_back(CHR_TAB);
        case ($urandom_range(0, 3))
          0, 1:    id = want_device;
          2:       id = {want_device[15:4], want_device[3:0] ^ 4'($urandom_range(1, 15))};
          default: id = 16'($urandom);
        endcase
        add_key_line(id);
      end
    end
    if ($urandom_range(0, 1) == 0) add_key_line(16'($urandom));
    db_text.push_back(CHR_NUL);
    // Occasionally corrupt one byte of an otherwise well-formed database.
    if ($urandom_range(0, 7) == 0)
      db_text[$urandom_range(0, db_text.size() - 1)] = 8'($urandom);
  endtask

  // Result side: stall pattern of its own and a check of every accepted word.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d data %h", out_tuser, out_tdata));
      end else begin
        want = pending_words.pop_front();
        if (out_tuser !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", out_tuser, want.kind));
        if (out_tdata[7:0] !== want.ch)
          flag_mismatch($sformatf("name_char %h, want %h", out_tdata[7:0], want.ch));
        if (out_tdata[9:8] !== want.verdict)
          flag_mismatch($sformatf("verdict %0d, want %0d", out_tdata[9:8], want.verdict));
        if (out_tdata[15:10] !== 6'd0)
          flag_mismatch($sformatf("pad bits %b not zero", out_tdata[15:10]));
      end
    end
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(10, 60);
    end
    ready_left--;
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Main sequence: reset, directed script, then randomized phases over several key settings.
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    load_keys(16'hFFFF, 16'h0000);
    foreach (script_rows[i])
      send_text(script_rows[i].txt, script_rows[i].restart, script_rows[i].fixed,
                script_rows[i].has_res, script_rows[i].res);
    for (int p = 1; p <= 5; p++) begin
      settle();
      case (p)
        1:       load_keys(16'h0000, 16'hFFFF);
        3:       load_keys(16'hFFFF, 16'hFFFF);
        5:       load_keys(16'h0000, 16'h0000);
        default: load_keys(16'($urandom), 16'($urandom));
      endcase
      while (text_count < 200 * p) begin
        make_database();
        foreach (db_text[i])
          send_text(db_text[i], (i == 0) && ($urandom_range(0, 9) != 0), PRED, 1'b0, '0);
      end
    end
    settle();
    if (mismatches == 0) begin
      $display("tb_pci_id_text_lookup_unit: clean");
    end else begin
      $display("tb_pci_id_text_lookup_unit: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/pidl_pkg.sv
sv/pidl_scan.sv
sv/pidl_queue.sv
sv/pidl_out.sv
sv/pci_id_text_lookup_unit.sv
test/tb_pci_id_text_lookup_unit.sv
